// ===== src/p2c_pkg.sv =====
// Constants and types for the polar-to-Cartesian CORDIC converter.
// Used by polar_to_cartesian; depends on nothing else.
`timescale 1ns / 1ps

package p2c_pkg;

    // Quadrant codes of the wrapped angle, in steps of 90 degrees.
    typedef logic [1:0] quad_t;
    localparam quad_t QUAD_0   = 2'd0;
    localparam quad_t QUAD_90  = 2'd1;
    localparam quad_t QUAD_180 = 2'd2;
    localparam quad_t QUAD_270 = 2'd3;

    localparam int ANGLE_IN_BITS = 24;
    localparam int MAX_STAGES    = 32;

    // Residual angle in units of 2^-24 degree, with headroom and sign.
    localparam int ZW = 33;

    // Inverse CORDIC gain in Q30.
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    // Multiple of 360 that lifts any 24-bit whole-degree value above zero.
    localparam logic [24:0] TURN_OFFSET = 25'd8388720;

    // floor(v / 45) = (v * DIV45_MUL) >> DIV45_SHIFT, exact for v below 2^22.
    localparam logic [22:0] DIV45_MUL   = 23'd5965233;
    localparam int          DIV45_SHIFT = 28;
    localparam logic [5:0]  DIV45_CONST = 6'd45;

    // atan(2^-i) in units of 2^-24 degree, rounded.
    localparam logic [29:0] ATAN_DEG24 [0:MAX_STAGES-1] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29,        30'd14,        30'd7,
        30'd4,         30'd2,         30'd1,         30'd0
    };

endpackage

// ===== src/polar_to_cartesian.sv =====
// Polar-to-Cartesian converter: angle wrap, CORDIC rotation, rounding and output buffer.
// Depends on p2c_pkg for the CORDIC constants, the atan table and the quadrant codes.
`timescale 1ns / 1ps

// Usage
//   Input stream s_axis: one item per polar pair (radius, angle_in). The angle is in
//   1/2^ANGLE_FRAC_BITS degree, with any number of turns; the radius magnitude is used.
//   Output stream m_axis: one item per input, (coord_x, coord_y, wrapped_angle).
//   Throughput: one item per clock cycle while the skid buffer is empty. Every stage
//   before the output register is a register stage advanced by one common enable, so
//   an item can enter in every cycle while that enable is high.
//   Stages: three stages of angle wrap and gain scaling, one stage per CORDIC
//   rotation, one rounding stage and the output register.
//   Stall: the output register is backed by a one-item skid buffer. While the receiver
//   stalls, the pipeline keeps running and s_axis_tready stays high until the skid
//   buffer fills; then the whole pipeline holds and s_axis_tready drops. Nothing is
//   lost or repeated.
//   Reset: rst_n clears all valid bits and the buffers; data registers are not reset.
module polar_to_cartesian #(
    parameter int RADIUS_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // radius, angle_in (from bit 0 up), zero padding to whole bytes
    input  logic [((RADIUS_BITS + p2c_pkg::ANGLE_IN_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // coord_x, coord_y, wrapped_angle (from bit 0 up), zero padding to whole bytes
    output logic [((2 * RADIUS_BITS + 9 + ANGLE_FRAC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int RB     = RADIUS_BITS;
    localparam int AF     = ANGLE_FRAC_BITS;
    localparam int AW     = p2c_pkg::ANGLE_IN_BITS;
    localparam int ZW     = p2c_pkg::ZW;
    localparam int NSTG   = (CORDIC_STAGES > p2c_pkg::MAX_STAGES) ?
                            p2c_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int NP     = NSTG + 4;
    localparam int XW     = RB + 32;
    localparam int RW     = RB + 2;
    localparam int WA_W   = 9 + AF;
    localparam int FW     = (AF > 0) ? AF : 1;
    localparam int OUT_TW = ((2 * RB + WA_W + 7) / 8) * 8;

    localparam logic [FW-1:0]        FRAC_MASK = FW'((64'd1 << AF) - 64'd1);
    localparam logic signed [XW-1:0] HALF_Q30  = XW'(64'd1 << 29);
    localparam logic signed [RW-1:0] LIM_POS   = RW'((64'd1 << (RB - 1)) - 64'd1);
    localparam logic signed [RW-1:0] LIM_NEG   = -LIM_POS;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic          vld_reg [0:NP-1];
    logic          skid_vld_reg;
    logic          out_vld_reg;
    logic          en;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: radius magnitude, whole degrees made positive
    // ------------------------------------------------------------------
    logic signed [RB-1:0] radius;
    logic signed [AW-1:0] angle_in;
    logic signed [RB-1:0] radius_neg;
    logic [RB-2:0]        mag_next;
    logic signed [AW-1:0] deg_whole;
    logic [AW:0]          deg_pos;

    logic [RB-2:0]        s1_mag_reg;
    logic [21:0]          s1_v_reg;
    logic [2:0]           s1_l3_reg;
    logic [FW-1:0]        s1_frac_reg;

    assign radius     = s_axis_tdata[RB-1:0];
    assign angle_in   = s_axis_tdata[RB+AW-1:RB];
    assign radius_neg = -radius;

    always_comb
    begin
        if (!radius[RB-1])
        begin
            mag_next = radius[RB-2:0];
        end
        else if (radius_neg[RB-1])
        begin
            // The most negative radius saturates to full scale.
            mag_next = '1;
        end
        else
        begin
            mag_next = radius_neg[RB-2:0];
        end
    end

    // The whole-degree part is floored, lifted by a multiple of 360 and then split
    // into multiples of 8 degrees (the low three bits pass straight into the remainder).
    assign deg_whole = angle_in >>> AF;
    assign deg_pos   = {deg_whole[AW-1], deg_whole} + p2c_pkg::TURN_OFFSET;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= mag_next;
            s1_v_reg    <= deg_pos[24:3];
            s1_l3_reg   <= deg_pos[2:0];
            s1_frac_reg <= angle_in[FW-1:0] & FRAC_MASK;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient by 45 and gain-scaled starting x
    // ------------------------------------------------------------------
    logic [44:0]    div_prod;
    logic [RB+28:0] x0_prod;

    logic [16:0]    s2_q45_reg;
    logic [21:0]    s2_v_reg;
    logic [2:0]     s2_l3_reg;
    logic [FW-1:0]  s2_frac_reg;
    logic [RB+28:0] s2_x0_reg;

    assign div_prod = 45'(s1_v_reg) * 45'(p2c_pkg::DIV45_MUL);
    assign x0_prod  = (RB + 29)'(s1_mag_reg) * (RB + 29)'(p2c_pkg::KINV_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_q45_reg  <= div_prod[p2c_pkg::DIV45_SHIFT +: 17];
            s2_v_reg    <= s1_v_reg;
            s2_l3_reg   <= s1_l3_reg;
            s2_frac_reg <= s1_frac_reg;
            s2_x0_reg   <= x0_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: degrees modulo 360, quadrant and residual angle
    // ------------------------------------------------------------------
    logic [22:0]           q45_times;
    logic [21:0]           rem45;
    logic [8:0]            deg_mod;
    p2c_pkg::quad_t        quad_next;
    logic [8:0]            resid_deg9;
    logic [6:0]            resid_deg;
    logic signed [ZW-1:0]  z0_next;
    logic [WA_W-1:0]       wrap_next;

    logic signed [XW-1:0]  cx_reg [0:NSTG];
    logic signed [XW-1:0]  cy_reg [0:NSTG];
    logic signed [ZW-1:0]  cz_reg [0:NSTG];
    p2c_pkg::quad_t        cq_reg [0:NSTG];
    logic [WA_W-1:0]       cw_reg [0:NSTG];

    assign q45_times = 23'(s2_q45_reg) * 23'(p2c_pkg::DIV45_CONST);
    assign rem45     = s2_v_reg - q45_times[21:0];
    assign deg_mod   = {rem45[5:0], s2_l3_reg};

    always_comb
    begin
        if (deg_mod >= 9'd270)
        begin
            quad_next  = p2c_pkg::QUAD_270;
            resid_deg9 = deg_mod - 9'd270;
        end
        else if (deg_mod >= 9'd180)
        begin
            quad_next  = p2c_pkg::QUAD_180;
            resid_deg9 = deg_mod - 9'd180;
        end
        else if (deg_mod >= 9'd90)
        begin
            quad_next  = p2c_pkg::QUAD_90;
            resid_deg9 = deg_mod - 9'd90;
        end
        else
        begin
            quad_next  = p2c_pkg::QUAD_0;
            resid_deg9 = deg_mod;
        end
    end

    assign resid_deg = resid_deg9[6:0];
    assign z0_next   = (ZW'(resid_deg) << 24) | (ZW'(s2_frac_reg) << (24 - AF));
    assign wrap_next = (WA_W'(deg_mod) << AF) | WA_W'(s2_frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= signed'({3'b000, s2_x0_reg});
            cy_reg[0] <= '0;
            cz_reg[0] <= z0_next;
            cq_reg[0] <= quad_next;
            cw_reg[0] <= wrap_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation stages, one micro-rotation per register stage
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NSTG; i++)
    begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] atan_z;

        assign dx     = cy_reg[i] >>> i;
        assign dy     = cx_reg[i] >>> i;
        assign atan_z = signed'({3'b000, p2c_pkg::ATAN_DEG24[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[i][ZW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - atan_z;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + atan_z;
                end
                cq_reg[i+1] <= cq_reg[i];
                cw_reg[i+1] <= cw_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding stage: Q30 to integer, ties toward plus infinity, then clamp
    // ------------------------------------------------------------------
    logic signed [XW-1:0] x_half;
    logic signed [XW-1:0] y_half;
    logic signed [RW-1:0] x_int;
    logic signed [RW-1:0] y_int;
    logic signed [RW-1:0] x_clip;
    logic signed [RW-1:0] y_clip;

    logic signed [RB-1:0] r_x_reg;
    logic signed [RB-1:0] r_y_reg;
    p2c_pkg::quad_t       r_q_reg;
    logic [WA_W-1:0]      r_w_reg;

    assign x_half = cx_reg[NSTG] + HALF_Q30;
    assign y_half = cy_reg[NSTG] + HALF_Q30;
    assign x_int  = x_half[XW-1:30];
    assign y_int  = y_half[XW-1:30];

    always_comb
    begin
        x_clip = x_int;
        if (x_int > LIM_POS)
        begin
            x_clip = LIM_POS;
        end
        else if (x_int < LIM_NEG)
        begin
            x_clip = LIM_NEG;
        end

        y_clip = y_int;
        if (y_int > LIM_POS)
        begin
            y_clip = LIM_POS;
        end
        else if (y_int < LIM_NEG)
        begin
            y_clip = LIM_NEG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_x_reg <= x_clip[RB-1:0];
            r_y_reg <= y_clip[RB-1:0];
            r_q_reg <= cq_reg[NSTG];
            r_w_reg <= cw_reg[NSTG];
        end
    end

    // ------------------------------------------------------------------
    // Quadrant mapping into the output register and skid buffer
    // ------------------------------------------------------------------
    logic signed [RB-1:0] map_x;
    logic signed [RB-1:0] map_y;

    logic signed [RB-1:0] out_x_reg;
    logic signed [RB-1:0] out_y_reg;
    logic [WA_W-1:0]      out_w_reg;
    logic signed [RB-1:0] skid_x_reg;
    logic signed [RB-1:0] skid_y_reg;
    logic [WA_W-1:0]      skid_w_reg;
    logic                 out_load;
    logic                 pipe_vld;

    always_comb
    begin
        case (r_q_reg)
            p2c_pkg::QUAD_0:
            begin
                map_x = r_x_reg;
                map_y = r_y_reg;
            end
            p2c_pkg::QUAD_90:
            begin
                map_x = -r_y_reg;
                map_y = r_x_reg;
            end
            p2c_pkg::QUAD_180:
            begin
                map_x = -r_x_reg;
                map_y = -r_y_reg;
            end
            default:
            begin
                map_x = r_y_reg;
                map_y = -r_x_reg;
            end
        endcase
    end

    assign pipe_vld = vld_reg[NP-1];
    assign out_load = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NP; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            skid_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg[0] <= s_axis_tvalid;
                for (int k = 1; k < NP; k++)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end

            if (out_load)
            begin
                if (skid_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                begin
                    out_vld_reg <= pipe_vld;
                end
            end
            else if (pipe_vld && en)
            begin
                // The receiver stalls while the pipeline delivers: park the item.
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_vld_reg)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
                out_w_reg <= skid_w_reg;
            end
            else
            begin
                out_x_reg <= map_x;
                out_y_reg <= map_y;
                out_w_reg <= r_w_reg;
            end
        end
        else if (en)
        begin
            skid_x_reg <= map_x;
            skid_y_reg <= map_y;
            skid_w_reg <= r_w_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_TW'({out_w_reg, out_y_reg, out_x_reg});

endmodule
